>>> rtl/gbfps_pkg.sv
package gbfps_pkg;

    localparam int GRID_SIZE      = 8;
    localparam int HEUR_FRAC_BITS = 8;
    localparam int CELLS          = 64;
    localparam int CELL_W         = 6;
    localparam int G_W            = 7;
    localparam int F_W            = G_W + HEUR_FRAC_BITS;
    localparam int SUM_W          = 7;
    localparam int SQ_IN_W        = SUM_W + 2 * HEUR_FRAC_BITS;
    localparam int SQ_W           = (SQ_IN_W + 1) / 2;
    localparam int SQ_CNT_W       = $clog2(SQ_W + 1);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH    = 2'd0,
        CFG_MAP_HEIGHT   = 2'd1,
        CFG_BLOCKED_MASK = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_POS_X = 2'd0,
        DIR_NEG_X = 2'd1,
        DIR_NEG_Y = 2'd2,
        DIR_POS_Y = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_NB,
        S_SQRT,
        S_INS,
        S_WALK,
        S_STEP,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic [CELL_W-1:0] loc;
        logic [G_W-1:0]    g;
        logic [F_W-1:0]    f;
    } t_open;

    typedef struct packed {
        logic init;
        logic scan_start;
        logic scan;
        logic pop;
        logic take;
        logic insert;
        logic dir_next;
        logic walk_init;
        logic walk_step;
        logic emit_init;
        logic emit;
        logic not_found;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic best_v;
        logic nb_ok;
        logic nb_goal;
        logic dir_last;
        logic sq_done;
        logic walk_end;
        logic emit_last;
    } t_stat;

    function automatic logic [CELL_W-1:0] pred_cell(input logic [CELL_W-1:0] c,
                                                    input logic [1:0] d);
        logic [CELL_W-1:0] p;
        p = c;
        unique case (t_dir'(d))
            DIR_POS_X: p = c - CELL_W'(1);
            DIR_NEG_X: p = c + CELL_W'(1);
            DIR_NEG_Y: p = c + CELL_W'(8);
            DIR_POS_Y: p = c - CELL_W'(8);
            default:   p = c;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/grid_best_first_path_search.sv
// Best-first path search on a 4-neighbor grid of up to 8 x 8 cells.
// A query (start and goal cell) is a transaction accepted on a rising edge
// with start high and busy low; busy then stays high until the final result
// is issued and falls in the cycle in which that result is on the ports.
// Results leave on o_point_x/o_point_y with o_found and o_last,
// each valid for exactly one cycle under o_strobe.
// A found path gives one result per cell from start to goal, the final one
// marked by o_last. No path gives a single result with o_found low.
// The receiver cannot stall; results are never held back.
// The search time is set by the open-list scan: each pop reads every entry
// inserted so far through one memory port. Neighbors are checked in turn,
// and each generated cell also passes through the iterative square-root
// unit and the insert. The path walk and output then go cell by cell.
// Queries are taken one at a time.
// Configuration transactions (index, data) are always ready and must be
// issued only while busy is low. Reset sets width and height to 8, clears the
// blocked mask and returns the block to idle.
module grid_best_first_path_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_start_x,
    input  logic [2:0]                          i_start_y,
    input  logic [2:0]                          i_goal_x,
    input  logic [2:0]                          i_goal_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gbfps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gbfps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_strobe,
    output logic [2:0]                          o_point_x,
    output logic [2:0]                          o_point_y,
    output logic                                o_found,
    output logic                                o_last
);

    logic [3:0]  r_map_w;
    logic [3:0]  r_map_h;
    logic [63:0] r_mask;

    logic [3:0]       n_w_sat;
    logic [3:0]       n_h_sat;
    gbfps_pkg::t_cmd  n_cmd;
    gbfps_pkg::t_stat n_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 4'd8;
            r_map_h <= 4'd8;
            r_mask  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (gbfps_pkg::t_cfg_idx'(i_cfg_index))
                gbfps_pkg::CFG_MAP_WIDTH:    r_map_w <= i_cfg_data[3:0];
                gbfps_pkg::CFG_MAP_HEIGHT:   r_map_h <= i_cfg_data[3:0];
                gbfps_pkg::CFG_BLOCKED_MASK: r_mask  <= i_cfg_data[63:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_w_sat = (r_map_w > 4'(gbfps_pkg::GRID_SIZE)) ? 4'(gbfps_pkg::GRID_SIZE) : r_map_w;
        n_h_sat = (r_map_h > 4'(gbfps_pkg::GRID_SIZE)) ? 4'(gbfps_pkg::GRID_SIZE) : r_map_h;
    end

    gbfps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (n_cmd),
        .i_stat  (n_stat)
    );

    gbfps_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (n_cmd),
        .o_stat    (n_stat),
        .i_width   (n_w_sat),
        .i_height  (n_h_sat),
        .i_mask    (r_mask),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_goal_x  (i_goal_x),
        .i_goal_y  (i_goal_y),
        .o_strobe  (o_strobe),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_found   (o_found),
        .o_last    (o_last)
    );

endmodule

>>> rtl/gbfps_sqrt.sv
module gbfps_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [gbfps_pkg::SQ_IN_W-1:0]     i_value,
    output logic [gbfps_pkg::SQ_W-1:0]        o_root,
    output logic                              o_busy
);

    logic [2*gbfps_pkg::SQ_W-1:0]   r_v;
    logic [gbfps_pkg::SQ_W+1:0]     r_rem;
    logic [gbfps_pkg::SQ_W-1:0]     r_q;
    logic [gbfps_pkg::SQ_CNT_W-1:0] r_cnt;

    logic [gbfps_pkg::SQ_W+1:0] n_rem;
    logic [gbfps_pkg::SQ_W+1:0] n_trial;

    always_comb begin
        n_rem   = {r_rem[gbfps_pkg::SQ_W-1:0], r_v[2*gbfps_pkg::SQ_W-1 -: 2]};
        n_trial = {r_q, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= gbfps_pkg::SQ_CNT_W'(gbfps_pkg::SQ_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= (2*gbfps_pkg::SQ_W)'(i_value);
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_v <= r_v << 2;
            if (n_rem >= n_trial) begin
                r_rem <= n_rem - n_trial;
                r_q   <= {r_q[gbfps_pkg::SQ_W-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_q   <= {r_q[gbfps_pkg::SQ_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_q;
    assign o_busy = (r_cnt != '0);

endmodule

>>> rtl/gbfps_dp.sv
module gbfps_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbfps_pkg::t_cmd      i_cmd,
    output gbfps_pkg::t_stat     o_stat,
    input  logic [3:0]           i_width,
    input  logic [3:0]           i_height,
    input  logic [63:0]          i_mask,
    input  logic [2:0]           i_start_x,
    input  logic [2:0]           i_start_y,
    input  logic [2:0]           i_goal_x,
    input  logic [2:0]           i_goal_y,
    output logic                 o_strobe,
    output logic [2:0]           o_point_x,
    output logic [2:0]           o_point_y,
    output logic                 o_found,
    output logic                 o_last
);

    localparam int CW = gbfps_pkg::CELL_W;

    gbfps_pkg::t_open r_open_mem [gbfps_pkg::CELLS];
    logic [1:0]       r_pdir_mem [gbfps_pkg::CELLS];
    logic [CW-1:0]    r_stk_mem  [gbfps_pkg::CELLS];

    logic [gbfps_pkg::CELLS-1:0] r_vis;
    logic [gbfps_pkg::CELLS-1:0] r_valid;
    logic [CW-1:0]               r_start;
    logic [CW-1:0]               r_goal;
    logic [CW:0]                 r_seq;
    logic [CW:0]                 r_scan;
    logic                        r_rd_on;
    logic [CW-1:0]               r_rd_idx;
    gbfps_pkg::t_open            r_open_rd;
    logic                        r_best_v;
    logic [CW-1:0]               r_best_idx;
    gbfps_pkg::t_open            r_best;
    logic [CW-1:0]               r_cur;
    logic [gbfps_pkg::G_W-1:0]   r_cur_g;
    logic [1:0]                  r_dir;
    logic [CW-1:0]               r_new_cell;
    logic [gbfps_pkg::G_W-1:0]   r_new_g;
    logic [CW-1:0]               r_wcur;
    logic [CW:0]                 r_n;
    logic [1:0]                  r_pd;
    logic [CW-1:0]               r_ptr;
    logic [CW-1:0]               r_stk_rd;
    logic                        r_strobe;
    logic [2:0]                  r_px;
    logic [2:0]                  r_py;
    logic                        r_found;
    logic                        r_last;

    logic [3:0]                  n_nx;
    logic [3:0]                  n_ny;
    logic [CW-1:0]               n_nb_cell;
    logic                        n_in_grid;
    logic [2:0]                  n_dx;
    logic [2:0]                  n_dy;
    logic [gbfps_pkg::SUM_W-1:0] n_sum;
    logic [gbfps_pkg::SQ_IN_W-1:0] n_sq_in;
    logic [gbfps_pkg::SQ_W-1:0]  n_root;
    logic                        n_sq_busy;
    logic [gbfps_pkg::F_W-1:0]   n_f;
    logic [CW-1:0]               n_prev;
    logic                        n_better;

    always_comb begin
        n_nx = {1'b0, r_cur[2:0]};
        n_ny = {1'b0, r_cur[5:3]};
        unique case (gbfps_pkg::t_dir'(r_dir))
            gbfps_pkg::DIR_POS_X: n_nx = {1'b0, r_cur[2:0]} + 4'd1;
            gbfps_pkg::DIR_NEG_X: n_nx = {1'b0, r_cur[2:0]} - 4'd1;
            gbfps_pkg::DIR_NEG_Y: n_ny = {1'b0, r_cur[5:3]} - 4'd1;
            gbfps_pkg::DIR_POS_Y: n_ny = {1'b0, r_cur[5:3]} + 4'd1;
            default: n_nx = {1'b0, r_cur[2:0]};
        endcase
        n_nb_cell = {n_ny[2:0], n_nx[2:0]};
        n_in_grid = (n_nx < i_width) && (n_ny < i_height);
        n_dx = (n_nx[2:0] > r_goal[2:0]) ? n_nx[2:0] - r_goal[2:0] : r_goal[2:0] - n_nx[2:0];
        n_dy = (n_ny[2:0] > r_goal[5:3]) ? n_ny[2:0] - r_goal[5:3] : r_goal[5:3] - n_ny[2:0];
        n_sum = gbfps_pkg::SUM_W'({3'b0, n_dx} * {3'b0, n_dx})
              + gbfps_pkg::SUM_W'({3'b0, n_dy} * {3'b0, n_dy});
        n_sq_in = {n_sum, {(2*gbfps_pkg::HEUR_FRAC_BITS){1'b0}}};
        n_f = {r_new_g, {gbfps_pkg::HEUR_FRAC_BITS{1'b0}}}
            + gbfps_pkg::F_W'(n_root);
        n_prev = gbfps_pkg::pred_cell(r_wcur, r_pd);
        n_better = r_rd_on && r_valid[r_rd_idx] && (!r_best_v || (r_open_rd.f < r_best.f));
    end

    gbfps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.take),
        .i_value (n_sq_in),
        .o_root  (n_root),
        .o_busy  (n_sq_busy)
    );

    always_comb begin
        o_stat.scan_done = (r_scan == r_seq) && !r_rd_on;
        o_stat.best_v    = r_best_v;
        o_stat.nb_ok     = n_in_grid && !i_mask[n_nb_cell] && !r_vis[n_nb_cell];
        o_stat.nb_goal   = (n_nb_cell == r_goal);
        o_stat.dir_last  = (gbfps_pkg::t_dir'(r_dir) == gbfps_pkg::DIR_POS_Y);
        o_stat.sq_done   = !n_sq_busy;
        o_stat.walk_end  = (r_wcur == r_start) || (r_n == (CW+1)'(gbfps_pkg::CELLS));
        o_stat.emit_last = (r_ptr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_open_mem[0] <= '{loc: {i_start_y, i_start_x}, g: '0, f: '0};
        end else if (i_cmd.insert) begin
            r_open_mem[r_seq[CW-1:0]] <= '{loc: r_new_cell, g: r_new_g, f: n_f};
        end
        r_open_rd <= r_open_mem[r_scan[CW-1:0]];
        if (i_cmd.take) begin
            r_pdir_mem[n_nb_cell] <= r_dir;
        end
        r_pd <= r_pdir_mem[r_wcur];
        if (i_cmd.walk_init) begin
            r_stk_mem[0] <= r_goal;
        end else if (i_cmd.walk_step) begin
            r_stk_mem[r_n[CW-1:0]] <= n_prev;
        end
        r_stk_rd <= r_stk_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis    <= '0;
            r_valid  <= '0;
            r_seq    <= '0;
            r_scan   <= '0;
            r_rd_on  <= 1'b0;
            r_best_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit || i_cmd.not_found;
            if (i_cmd.init) begin
                r_vis   <= gbfps_pkg::CELLS'(1) << {i_start_y, i_start_x};
                r_valid <= gbfps_pkg::CELLS'(1);
                r_seq   <= (CW+1)'(1);
            end else begin
                if (i_cmd.take) begin
                    r_vis[n_nb_cell] <= 1'b1;
                end
                if (i_cmd.pop) begin
                    r_valid[r_best_idx] <= 1'b0;
                end
                if (i_cmd.insert) begin
                    r_valid[r_seq[CW-1:0]] <= 1'b1;
                    r_seq <= r_seq + 1'b1;
                end
            end
            if (i_cmd.init || i_cmd.scan_start) begin
                r_scan   <= '0;
                r_rd_on  <= 1'b0;
                r_best_v <= 1'b0;
            end else begin
                r_rd_on <= i_cmd.scan && (r_scan < r_seq);
                if (i_cmd.scan && (r_scan < r_seq)) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (n_better) begin
                    r_best_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan[CW-1:0];
        if (n_better) begin
            r_best     <= r_open_rd;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.init) begin
            r_start <= {i_start_y, i_start_x};
            r_goal  <= {i_goal_y, i_goal_x};
        end
        if (i_cmd.pop) begin
            r_cur   <= r_best.loc;
            r_cur_g <= r_best.g;
            r_dir   <= gbfps_pkg::DIR_POS_X;
        end else if (i_cmd.dir_next) begin
            r_dir <= r_dir + 1'b1;
        end
        if (i_cmd.take) begin
            r_new_cell <= n_nb_cell;
            r_new_g    <= r_cur_g + 1'b1;
        end
        if (i_cmd.walk_init) begin
            r_wcur <= r_goal;
            r_n    <= (CW+1)'(1);
        end else if (i_cmd.walk_step) begin
            r_wcur <= n_prev;
            r_n    <= r_n + 1'b1;
        end
        if (i_cmd.emit_init) begin
            r_ptr <= CW'(r_n - 1'b1);
        end else if (i_cmd.emit) begin
            r_ptr <= r_ptr - 1'b1;
        end
        if (i_cmd.emit) begin
            r_px    <= r_stk_rd[2:0];
            r_py    <= r_stk_rd[5:3];
            r_found <= 1'b1;
            r_last  <= (r_ptr == '0);
        end else if (i_cmd.not_found) begin
            r_px    <= '0;
            r_py    <= '0;
            r_found <= 1'b0;
            r_last  <= 1'b1;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_point_x = r_px;
    assign o_point_y = r_py;
    assign o_found   = r_found;
    assign o_last    = r_last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_seq < (CW+1)'(gbfps_pkg::CELLS)))
        else $error("Open list written beyond its depth.");

    a_nf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_found) |-> r_last)
        else $error("A not-found result must end the query.");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |=> !r_strobe)
        else $error("Result follows the final result of a query.");

endmodule

>>> rtl/gbfps_ctrl.sv
module gbfps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output gbfps_pkg::t_cmd  o_cmd,
    input  gbfps_pkg::t_stat i_stat
);

    gbfps_pkg::t_state r_state;
    gbfps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbfps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            gbfps_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.init = 1'b1;
                    n_state    = gbfps_pkg::S_SCAN;
                end
            end
            gbfps_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = gbfps_pkg::S_POP;
                end
            end
            gbfps_pkg::S_POP: begin
                if (i_stat.best_v) begin
                    o_cmd.pop = 1'b1;
                    n_state   = gbfps_pkg::S_NB;
                end else begin
                    o_cmd.not_found = 1'b1;
                    n_state         = gbfps_pkg::S_IDLE;
                end
            end
            gbfps_pkg::S_NB: begin
                if (i_stat.nb_ok) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.nb_goal) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = gbfps_pkg::S_WALK;
                    end else begin
                        n_state = gbfps_pkg::S_SQRT;
                    end
                end else if (i_stat.dir_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = gbfps_pkg::S_SCAN;
                end else begin
                    o_cmd.dir_next = 1'b1;
                end
            end
            gbfps_pkg::S_SQRT: begin
                if (i_stat.sq_done) begin
                    n_state = gbfps_pkg::S_INS;
                end
            end
            gbfps_pkg::S_INS: begin
                o_cmd.insert = 1'b1;
                if (i_stat.dir_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = gbfps_pkg::S_SCAN;
                end else begin
                    o_cmd.dir_next = 1'b1;
                    n_state        = gbfps_pkg::S_NB;
                end
            end
            gbfps_pkg::S_WALK: begin
                if (i_stat.walk_end) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = gbfps_pkg::S_EMIT_RD;
                end else begin
                    n_state = gbfps_pkg::S_STEP;
                end
            end
            gbfps_pkg::S_STEP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = gbfps_pkg::S_WALK;
            end
            gbfps_pkg::S_EMIT_RD: begin
                n_state = gbfps_pkg::S_EMIT_OUT;
            end
            gbfps_pkg::S_EMIT_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_stat.emit_last ? gbfps_pkg::S_IDLE : gbfps_pkg::S_EMIT_RD;
            end
            default: begin
                n_state = gbfps_pkg::S_IDLE;
            end
        endcase
    end

    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("Block not busy after accepting a query.");

    a_take_in_nb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> (r_state == gbfps_pkg::S_NB && i_stat.nb_ok))
        else $error("Cell generated outside neighbor evaluation.");

    a_emit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> $past(r_state == gbfps_pkg::S_EMIT_RD))
        else $error("Path result issued without a stack read.");

endmodule
